@@ hw/rtl/oal_pkg.sv @@
// Shared types, codes and field widths for the ordered array list.
// No dependencies; every other file of the block imports this package.
package oal_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int VALUE_BITS_DEF = 32;

  localparam int KIND_W    = 3;
  localparam int POS_W     = 6;
  localparam int DATA_W    = 32;
  localparam int STAT_W    = 2;
  localparam int CNT_OUT_W = 7;
  localparam int MAX_W     = 7;

  // Width used for position and count comparisons; holds any count plus one.
  localparam int ARITH_W = 8;

  localparam logic [MAX_W-1:0] MAX_ENTRIES_RST = 7'd64;

  localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_GET    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SET    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FIND   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_APPEND = 3'd5;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd6;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_MISS  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // latch the command beat and its checks
    logic rd;      // read the entry at the walk pointer and step it
    logic proc;    // use the entry read in the previous cycle
    logic put;     // write the command value into its slot
    logic finish;  // update the count and register the result beat
  } oal_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk;    // the command needs a walk over the entries
    logic put;     // the command ends with a write of its value
    logic at_end;  // the walk pointer sits on the last entry to read
    logic hit;     // the entry read last cycle matches the search value
    logic ins;     // the command is an insert
  } oal_stat_t;

endpackage

@@ hw/rtl/oal_ctrl.sv @@
// Sequencing state machine of the ordered array list.
// Depends on oal_pkg for the command and status structs.
module oal_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  oal_pkg::oal_stat_t stat_i,
  output oal_pkg::oal_cmd_t  cmd_o
);
  import oal_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_WALK   = 6'b000100,
    S_LAST   = 6'b001000,
    S_PUT    = 6'b010000,
    S_FINISH = 6'b100000
  } ctl_state_t;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    case (state_r)
      S_IDLE: begin
        cmd_o.load = start;
        if (start) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        if (stat_i.walk)     state_nxt = S_WALK;
        else if (stat_i.put) state_nxt = S_PUT;
        else                 state_nxt = S_FINISH;
      end
      S_WALK: begin
        // One read issued per cycle; the previous read is shifted, compared or captured.
        cmd_o.rd   = 1'b1;
        cmd_o.proc = 1'b1;
        if (stat_i.hit)         state_nxt = S_FINISH;
        else if (stat_i.at_end) state_nxt = S_LAST;
      end
      S_LAST: begin
        cmd_o.proc = 1'b1;
        state_nxt  = stat_i.ins ? S_PUT : S_FINISH;
      end
      S_PUT: begin
        cmd_o.put = 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

@@ hw/rtl/oal_dpath.sv @@
// Datapath of the ordered array list: entry memory, count, capacity register,
// walk pointer and result registers. Depends on oal_pkg.
module oal_dpath #(
  parameter int CAPACITY   = oal_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = oal_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  oal_pkg::oal_cmd_t                   cmd_i,
  output oal_pkg::oal_stat_t                  stat_o,
  input  logic [oal_pkg::KIND_W-1:0]          in_kind,
  input  logic [oal_pkg::POS_W-1:0]           in_position,
  input  logic signed [oal_pkg::DATA_W-1:0]   in_data_value,
  input  logic                                cfg_wr,
  input  logic [oal_pkg::MAX_W-1:0]           cfg_data,
  output logic                                out_strobe,
  output logic [oal_pkg::STAT_W-1:0]          out_status,
  output logic signed [oal_pkg::DATA_W-1:0]   out_read_value,
  output logic                                out_found,
  output logic [oal_pkg::POS_W-1:0]           out_found_position,
  output logic [oal_pkg::CNT_OUT_W-1:0]       out_entry_count,
  output logic                                out_is_full,
  output logic                                out_is_empty
);
  import oal_pkg::*;

  // The capacity register cannot exceed 127, so neither can the count.
  localparam int CAP_LIM = (CAPACITY < 127) ? CAPACITY : 127;
  localparam int ADDR_W  = $clog2(CAP_LIM);
  localparam int CNT_W   = $clog2(CAP_LIM + 1);
  localparam logic [ARITH_W-1:0] CAP_LIM_E = ARITH_W'(CAP_LIM);

  logic [VALUE_BITS-1:0] mem [CAP_LIM];
  logic [VALUE_BITS-1:0] rdata_r;

  logic [MAX_W-1:0]      max_r;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [KIND_W-1:0]     kind_r;
  logic [POS_W-1:0]      pos_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [STAT_W-1:0]     status_r;
  logic                  walk_r, put_r, rv_r, found_r;
  logic [ADDR_W-1:0]     idx_r, end_r, last_r;
  logic [VALUE_BITS-1:0] rd_r;
  logic [POS_W-1:0]      fpos_r;

  logic                  out_strobe_r;
  logic [STAT_W-1:0]     out_status_r;
  logic [DATA_W-1:0]     out_read_value_r;
  logic                  out_found_r;
  logic [POS_W-1:0]      out_found_position_r;
  logic [CNT_OUT_W-1:0]  out_entry_count_r;
  logic                  out_is_full_r, out_is_empty_r;

  // Checks made when a command beat is taken.
  logic [ARITH_W-1:0]    pos_e, cnt_e, cap_e;
  logic [MAX_W-1:0]      cap;
  logic                  full;
  logic [STAT_W-1:0]     ld_status;
  logic                  ld_walk, ld_put;
  logic [ARITH_W-1:0]    ld_idx, ld_end;

  always_comb begin
    cap       = (ARITH_W'(max_r) > CAP_LIM_E) ? MAX_W'(CAP_LIM) : max_r;
    pos_e     = ARITH_W'(in_position);
    cnt_e     = ARITH_W'(cnt_r);
    cap_e     = ARITH_W'(cap);
    full      = (cnt_e >= cap_e);
    ld_status = ST_OK;
    ld_walk   = 1'b0;
    ld_put    = 1'b0;
    ld_idx    = '0;
    ld_end    = '0;
    case (in_kind)
      KIND_INSERT: begin
        ld_idx = cnt_e - 8'd1;
        ld_end = pos_e;
        if (pos_e > cnt_e) begin
          ld_status = ST_RANGE;
        end else if (full) begin
          ld_status = ST_FULL;
        end else begin
          ld_put  = 1'b1;
          ld_walk = (pos_e < cnt_e);
        end
      end
      KIND_REMOVE: begin
        ld_idx = pos_e + 8'd1;
        ld_end = cnt_e - 8'd1;
        if (pos_e >= cnt_e) ld_status = ST_RANGE;
        else                ld_walk   = ((pos_e + 8'd1) < cnt_e);
      end
      KIND_GET: begin
        ld_idx = pos_e;
        ld_end = pos_e;
        if (pos_e >= cnt_e) ld_status = ST_RANGE;
        else                ld_walk   = 1'b1;
      end
      KIND_SET: begin
        if (pos_e >= cnt_e) ld_status = ST_RANGE;
        else                ld_put    = 1'b1;
      end
      KIND_FIND: begin
        ld_idx  = '0;
        ld_end  = cnt_e - 8'd1;
        ld_walk = (cnt_e != '0);
      end
      KIND_APPEND: begin
        if (full) ld_status = ST_FULL;
        else      ld_put    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  logic match;
  assign match = (rdata_r == val_r);

  assign stat_o.walk   = walk_r;
  assign stat_o.put    = put_r;
  assign stat_o.at_end = (idx_r == end_r);
  assign stat_o.hit    = rv_r && (kind_r == KIND_FIND) && match;
  assign stat_o.ins    = (kind_r == KIND_INSERT);

  // Single write port: shifted entry during a walk, or the command value.
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic [VALUE_BITS-1:0] wr_data;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = rdata_r;
    if (cmd_i.put) begin
      wr_en   = 1'b1;
      wr_addr = (kind_r == KIND_APPEND) ? ADDR_W'(cnt_r) : ADDR_W'(pos_r);
      wr_data = val_r;
    end else if (cmd_i.proc && rv_r) begin
      if (kind_r == KIND_INSERT) begin
        wr_en   = 1'b1;
        wr_addr = last_r + 1'b1;
      end else if (kind_r == KIND_REMOVE) begin
        wr_en   = 1'b1;
        wr_addr = last_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd_i.rd) rdata_r <= mem[idx_r];
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (status_r == ST_OK) begin
      case (kind_r)
        KIND_INSERT, KIND_APPEND: cnt_nxt = cnt_r + 1'b1;
        KIND_REMOVE:              cnt_nxt = cnt_r - 1'b1;
        KIND_CLEAR:               cnt_nxt = '0;
        default:                  cnt_nxt = cnt_r;
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r        <= MAX_ENTRIES_RST;
      cnt_r        <= '0;
      rv_r         <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cfg_wr) max_r <= cfg_data;
      if (cmd_i.finish) cnt_r <= cnt_nxt;
      rv_r         <= cmd_i.rd;
      out_strobe_r <= cmd_i.finish;
    end
  end

  // Command payload, walk pointer and result registers.
  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      kind_r   <= in_kind;
      pos_r    <= in_position;
      val_r    <= VALUE_BITS'($unsigned(in_data_value));
      status_r <= ld_status;
      walk_r   <= ld_walk;
      put_r    <= ld_put;
      idx_r    <= ADDR_W'(ld_idx);
      end_r    <= ADDR_W'(ld_end);
      rd_r     <= '0;
      found_r  <= 1'b0;
      fpos_r   <= '0;
    end
    if (cmd_i.rd) begin
      last_r <= idx_r;
      idx_r  <= (kind_r == KIND_INSERT) ? idx_r - 1'b1 : idx_r + 1'b1;
    end
    if (cmd_i.proc && rv_r) begin
      if (kind_r == KIND_GET) rd_r <= rdata_r;
      if ((kind_r == KIND_FIND) && match && !found_r) begin
        found_r <= 1'b1;
        fpos_r  <= POS_W'(last_r);
      end
    end
    if (cmd_i.finish) begin
      out_status_r         <= ((kind_r == KIND_FIND) && !found_r) ? ST_MISS : status_r;
      out_read_value_r     <= DATA_W'(rd_r);
      out_found_r          <= found_r;
      out_found_position_r <= fpos_r;
      out_entry_count_r    <= CNT_OUT_W'(cnt_nxt);
      out_is_full_r        <= (ARITH_W'(cnt_nxt) >= cap_e);
      out_is_empty_r       <= (cnt_nxt == '0);
    end
  end

  assign out_strobe         = out_strobe_r;
  assign out_status         = out_status_r;
  assign out_read_value     = out_read_value_r;
  assign out_found          = out_found_r;
  assign out_found_position = out_found_position_r;
  assign out_entry_count    = out_entry_count_r;
  assign out_is_full        = out_is_full_r;
  assign out_is_empty       = out_is_empty_r;

endmodule

@@ hw/rtl/ordered_array_list_core.sv @@
// Top level of the ordered array list: controller and datapath joined.
// Depends on oal_pkg, oal_ctrl and oal_dpath.
//
//  channel  | ports                                  | beat taken when
//  ---------+----------------------------------------+----------------------
//  command  | start, busy, in_kind/position/data_value | start && !busy
//  result   | out_strobe, out_status ... out_is_empty  | every out_strobe cycle
//  config   | cfg_valid, cfg_ready, cfg_data         | cfg_valid && cfg_ready
//
// A command that neither walks nor writes (clear, an error, the unused kind, find on an empty
// list, removal of the last entry) goes from decode straight to finish, where its result beat
// is registered; one that only writes its value (set, append, insert at the end) first passes
// a write state. A walk reads the single-read-port entry memory one entry at a time: insert
// from the last entry down to its position, remove the entries after its position, get the
// one entry, and find from the first entry until a match or the end; insert then writes.
// Busy is high from the cycle after acceptance until the result is registered, and a
// configuration beat is taken only while the block is idle and no command is offered.
// Reset is synchronous; it clears the count and sets the capacity to 64, and
// the entry memory is not cleared. Results cannot be held off by the receiver.
module ordered_array_list_core #(
  parameter int CAPACITY   = oal_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = oal_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [oal_pkg::KIND_W-1:0]          in_kind,
  input  logic [oal_pkg::POS_W-1:0]           in_position,
  input  logic signed [oal_pkg::DATA_W-1:0]   in_data_value,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [oal_pkg::MAX_W-1:0]           cfg_data,
  output logic                                out_strobe,
  output logic [oal_pkg::STAT_W-1:0]          out_status,
  output logic signed [oal_pkg::DATA_W-1:0]   out_read_value,
  output logic                                out_found,
  output logic [oal_pkg::POS_W-1:0]           out_found_position,
  output logic [oal_pkg::CNT_OUT_W-1:0]       out_entry_count,
  output logic                                out_is_full,
  output logic                                out_is_empty
);
  import oal_pkg::*;

  oal_cmd_t  cmd;
  oal_stat_t stat;

  // A command beat offered in the same cycle takes precedence over a capacity write.
  assign cfg_ready = !busy && !start;

  oal_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  oal_dpath #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .in_kind            (in_kind),
    .in_position        (in_position),
    .in_data_value      (in_data_value),
    .cfg_wr             (cfg_valid && cfg_ready),
    .cfg_data           (cfg_data),
    .out_strobe         (out_strobe),
    .out_status         (out_status),
    .out_read_value     (out_read_value),
    .out_found          (out_found),
    .out_found_position (out_found_position),
    .out_entry_count    (out_entry_count),
    .out_is_full        (out_is_full),
    .out_is_empty       (out_is_empty)
  );

endmodule

@@ hw/rtl/oal_checker.sv @@
// Port-level checks for ordered_array_list_core and the bind that attaches them.
// Depends on oal_pkg and on the top level's port list.
module oal_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             start,
  input logic                             busy,
  input logic                             out_strobe,
  input logic [oal_pkg::STAT_W-1:0]       out_status,
  input logic                             out_found,
  input logic [oal_pkg::CNT_OUT_W-1:0]    out_entry_count,
  input logic                             out_is_empty
);
  import oal_pkg::*;

  // After reset the block is idle and shows no result beat.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_strobe))
    else $error("block not idle after reset");

  // An accepted command beat makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("command beat accepted but block not busy");

  // Each command yields a single result beat, never two in a row.
  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for more than one cycle");

  // The empty flag agrees with the reported count.
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_is_empty == (out_entry_count == '0)))
    else $error("empty flag disagrees with entry count");

  // A successful find always reports status ok.
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_found) |-> (out_status == ST_OK))
    else $error("found flag set with an error status");

endmodule

bind ordered_array_list_core oal_checker u_oal_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_strobe      (out_strobe),
  .out_status      (out_status),
  .out_found       (out_found),
  .out_entry_count (out_entry_count),
  .out_is_empty    (out_is_empty)
);
